FILE: hw/rtl/hwd_pkg.sv
// hwd_pkg: request, response and queue entry types and codes for the word dictionary
// no dependencies
`default_nettype none

package hwd_pkg;

   localparam int unsigned WORD_LEN_W  = 6;
   localparam int unsigned HASH_W      = 32;
   localparam int unsigned COUNT_W     = 11;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_TOO_LONG  = 2'd1;
   localparam logic [1:0] STATUS_POOL_FULL = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] char_code;
      logic       last;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [1:0]         status;
      logic [COUNT_W-1:0] word_count;
   } rsp_type;

   // one classified character or a clear, passed from front to back
   typedef struct packed {
      logic                  is_clear;
      logic [7:0]            ch;
      logic                  keep;
      logic [WORD_LEN_W-1:0] idx;
      logic                  last;
      logic                  insert;
      logic [WORD_LEN_W-1:0] length;
      logic                  too_long;
      logic [HASH_W-1:0]     hash;
   } entry_type;

endpackage

`default_nettype wire

FILE: hw/rtl/hwd_front.sv
// hwd_front: takes requests, lowercases lookups, hashes and counts the word
// depends on hwd_pkg
`default_nettype none

module hwd_front #(
   parameter int unsigned MAX_WORD = 45
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  hwd_pkg::req_type    req_data,
   input  wire                 queue_full,
   output logic                push,
   output hwd_pkg::entry_type  push_entry
);

   localparam int unsigned LW = $clog2(MAX_WORD + 1);

   logic [LW-1:0]              len_ff, len_in;
   logic [hwd_pkg::HASH_W-1:0] hash_ff, hash_in;
   logic                       too_long_ff, too_long_in;

   logic [7:0]                 c_low;
   logic [hwd_pkg::HASH_W-1:0] hash_nx;
   logic [LW-1:0]              len_nx;
   logic                       keep;
   logic                       accept;
   logic                       is_word_op;
   logic                       is_clear;

   assign req_ready  = !queue_full;
   assign accept     = req_valid && req_ready;
   assign is_word_op = (req_data.op == hwd_pkg::OP_LOOKUP) || (req_data.op == hwd_pkg::OP_INSERT);
   assign is_clear   = (req_data.op == hwd_pkg::OP_CLEAR);
   assign push       = accept && (is_word_op || is_clear);

   always_comb begin
      c_low = req_data.char_code;
      if (req_data.op == hwd_pkg::OP_LOOKUP && req_data.char_code >= 8'h41
          && req_data.char_code <= 8'h5A) begin
         c_low = req_data.char_code + 8'd32;
      end
      hash_nx = {hash_ff[hwd_pkg::HASH_W-3:0], 2'b00} ^ {24'd0, c_low};
      keep    = len_ff < LW'(MAX_WORD);
      len_nx  = keep ? len_ff + LW'(1) : len_ff;
   end

   always_comb begin
      push_entry          = '0;
      push_entry.is_clear = is_clear;
      push_entry.ch       = c_low;
      push_entry.keep     = keep;
      push_entry.idx      = hwd_pkg::WORD_LEN_W'(len_ff);
      push_entry.last     = req_data.last;
      push_entry.insert   = (req_data.op == hwd_pkg::OP_INSERT);
      push_entry.length   = hwd_pkg::WORD_LEN_W'(len_nx);
      push_entry.too_long = too_long_ff || !keep;
      push_entry.hash     = hash_nx;
   end

   always_comb begin
      len_in      = len_ff;
      hash_in     = hash_ff;
      too_long_in = too_long_ff;
      if (accept) begin
         if (is_clear || (is_word_op && req_data.last)) begin
            len_in      = '0;
            hash_in     = '0;
            too_long_in = 1'b0;
         end else if (is_word_op) begin
            len_in      = len_nx;
            hash_in     = hash_nx;
            too_long_in = too_long_ff || !keep;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         hash_ff     <= '0;
         too_long_ff <= 1'b0;
      end else begin
         len_ff      <= len_in;
         hash_ff     <= hash_in;
         too_long_ff <= too_long_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/hwd_fifo.sv
// hwd_fifo: short queue of classified entries between front and back
// depends on hwd_pkg
`default_nettype none

module hwd_fifo (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  hwd_pkg::entry_type  push_entry,
   input  wire                 pop,
   output hwd_pkg::entry_type  pop_entry,
   output logic                full,
   output logic                empty
);

   localparam int unsigned PTR_W = $clog2(hwd_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(hwd_pkg::QUEUE_DEPTH + 1);

   hwd_pkg::entry_type slot_ff [hwd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = count_ff == CNT_W'(hwd_pkg::QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> (!full || pop))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(hwd_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/hwd_back.sv
// hwd_back: buckets, node pool and word buffer; runs lookups, inserts and clears
// depends on hwd_pkg
`default_nettype none

module hwd_back #(
   parameter int unsigned MAX_WORD   = 45,
   parameter int unsigned BUCKETS    = 4096,
   parameter int unsigned POOL_NODES = 1024
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 queue_empty,
   input  hwd_pkg::entry_type  pop_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output hwd_pkg::rsp_type    rsp_data
);

   localparam int unsigned LW = $clog2(MAX_WORD + 1);
   localparam int unsigned IW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int unsigned BW = $clog2(BUCKETS);
   localparam int unsigned PW = $clog2(POOL_NODES + 1);
   localparam int unsigned NW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int unsigned CHAR_DEPTH = POOL_NODES * (1 << IW);
   localparam bit          BUCKETS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

   typedef enum logic [3:0] {
      S_SWEEP, S_IDLE, S_MOD, S_HRD, S_HUSE, S_NODE, S_META,
      S_CRD, S_CCHK, S_CPRD, S_CPWR, S_INS_LINK, S_DONE
   } state_type;

   state_type             state_ff;
   logic [BW-1:0]         sweep_idx_ff;
   logic                  sweep_pend_ff;
   logic [PW-1:0]         nodes_used_ff;
   logic [LW-1:0]         wlen_ff;
   logic                  ins_ff;
   logic [BW-1:0]         bucket_ff;
   logic [BW-1:0]         rem_ff;
   logic [hwd_pkg::HASH_W-1:0] mod_sh_ff;
   logic [4:0]            mod_cnt_ff;
   logic [PW-1:0]         ref_ff;
   logic [PW-1:0]         link_ff;
   logic [IW-1:0]         idx_ff;
   hwd_pkg::rsp_type      result_ff;
   logic                  rsp_valid_ff;
   hwd_pkg::rsp_type      rsp_data_ff;

   // memories
   logic [PW-1:0]         head_mem [BUCKETS];
   logic [PW-1:0]         head_rd_ff;
   logic [LW+PW-1:0]      meta_mem [POOL_NODES];
   logic [LW+PW-1:0]      meta_rd_ff;
   logic [7:0]            char_mem [CHAR_DEPTH];
   logic [7:0]            char_rd_ff;
   logic [7:0]            wbuf_mem [MAX_WORD];
   logic [7:0]            wbuf_rd_ff;

   logic                  head_we;
   logic [BW-1:0]         head_wa;
   logic [PW-1:0]         head_wd;
   logic [NW-1:0]         nd;
   logic [NW-1:0]         new_nd;
   logic [BW:0]           rem_sh;
   logic [BW-1:0]         rem_nx;
   logic                  out_free;
   logic                  idx_is_end;
   logic [LW-1:0]         meta_len;
   logic [PW-1:0]         meta_link;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign pop        = (state_ff == S_IDLE) && !queue_empty;
   assign nd         = NW'(ref_ff - PW'(1));
   assign new_nd     = NW'(nodes_used_ff);
   assign idx_is_end = (LW'(idx_ff) + LW'(1)) == wlen_ff;
   assign meta_len   = meta_rd_ff[LW+PW-1:PW];
   assign meta_link  = meta_rd_ff[PW-1:0];

   // one step of restoring remainder by the bucket count
   always_comb begin
      rem_sh = {rem_ff, mod_sh_ff[hwd_pkg::HASH_W-1]};
      rem_nx = (rem_sh >= (BW+1)'(BUCKETS)) ? BW'(rem_sh - (BW+1)'(BUCKETS)) : BW'(rem_sh);
   end

   always_comb begin
      head_we = 1'b0;
      head_wa = bucket_ff;
      head_wd = '0;
      if (state_ff == S_SWEEP) begin
         head_we = 1'b1;
         head_wa = sweep_idx_ff;
      end else if (state_ff == S_INS_LINK) begin
         head_we = 1'b1;
         head_wd = nodes_used_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_rd_ff <= head_mem[bucket_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_INS_LINK) begin
         meta_mem[new_nd] <= {wlen_ff, link_ff};
      end
      meta_rd_ff <= meta_mem[nd];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CPWR) begin
         char_mem[{new_nd, idx_ff}] <= wbuf_rd_ff;
      end
      char_rd_ff <= char_mem[{nd, idx_ff}];
   end

   always_ff @(posedge clock) begin
      if (pop && !pop_entry.is_clear && pop_entry.keep) begin
         wbuf_mem[pop_entry.idx[IW-1:0]] <= pop_entry.ch;
      end
      wbuf_rd_ff <= wbuf_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         sweep_idx_ff  <= '0;
         sweep_pend_ff <= 1'b0;
         nodes_used_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // in S_DONE the valid flag is handled by that state alone
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_SWEEP: begin
               sweep_idx_ff <= sweep_idx_ff + BW'(1);
               if (sweep_idx_ff == BW'(BUCKETS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               sweep_idx_ff  <= '0;
               sweep_pend_ff <= 1'b0;
               if (!queue_empty) begin
                  wlen_ff <= LW'(pop_entry.length);
                  ins_ff  <= pop_entry.insert;
                  if (pop_entry.is_clear) begin
                     nodes_used_ff <= '0;
                     result_ff     <= '{found: 1'b0, status: hwd_pkg::STATUS_DONE,
                                        word_count: '0};
                     sweep_pend_ff <= 1'b1;
                     state_ff      <= S_DONE;
                  end else if (pop_entry.last) begin
                     if (pop_entry.too_long) begin
                        result_ff <= '{found: 1'b0, status: hwd_pkg::STATUS_TOO_LONG,
                                      word_count: hwd_pkg::COUNT_W'(nodes_used_ff)};
                        state_ff  <= S_DONE;
                     end else if (pop_entry.insert && nodes_used_ff >= PW'(POOL_NODES)) begin
                        nodes_used_ff <= '0;
                        result_ff     <= '{found: 1'b0, status: hwd_pkg::STATUS_POOL_FULL,
                                          word_count: '0};
                        sweep_pend_ff <= 1'b1;
                        state_ff      <= S_DONE;
                     end else if (BUCKETS_POW2) begin
                        bucket_ff <= pop_entry.hash[BW-1:0];
                        state_ff  <= S_HRD;
                     end else begin
                        rem_ff     <= '0;
                        mod_sh_ff  <= pop_entry.hash;
                        mod_cnt_ff <= '0;
                        state_ff   <= S_MOD;
                     end
                  end
               end
            end
            S_MOD: begin
               rem_ff     <= rem_nx;
               mod_sh_ff  <= {mod_sh_ff[hwd_pkg::HASH_W-2:0], 1'b0};
               mod_cnt_ff <= mod_cnt_ff + 5'd1;
               if (mod_cnt_ff == 5'd31) begin
                  bucket_ff <= rem_nx;
                  state_ff  <= S_HRD;
               end
            end
            S_HRD: begin
               state_ff <= S_HUSE;
            end
            S_HUSE: begin
               idx_ff <= '0;
               if (ins_ff) begin
                  link_ff  <= head_rd_ff;
                  state_ff <= (wlen_ff == '0) ? S_INS_LINK : S_CPRD;
               end else begin
                  ref_ff   <= head_rd_ff;
                  state_ff <= S_NODE;
               end
            end
            S_NODE: begin
               if (ref_ff == '0) begin
                  result_ff <= '{found: 1'b0, status: hwd_pkg::STATUS_DONE,
                                word_count: hwd_pkg::COUNT_W'(nodes_used_ff)};
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_META;
               end
            end
            S_META: begin
               link_ff <= meta_link;
               idx_ff  <= '0;
               if (meta_len != wlen_ff) begin
                  ref_ff   <= meta_link;
                  state_ff <= S_NODE;
               end else if (wlen_ff == '0) begin
                  result_ff <= '{found: 1'b1, status: hwd_pkg::STATUS_DONE,
                                word_count: hwd_pkg::COUNT_W'(nodes_used_ff)};
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_CRD;
               end
            end
            S_CRD: begin
               state_ff <= S_CCHK;
            end
            S_CCHK: begin
               if (char_rd_ff != wbuf_rd_ff) begin
                  ref_ff   <= link_ff;
                  state_ff <= S_NODE;
               end else if (idx_is_end) begin
                  result_ff <= '{found: 1'b1, status: hwd_pkg::STATUS_DONE,
                                word_count: hwd_pkg::COUNT_W'(nodes_used_ff)};
                  state_ff  <= S_DONE;
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_CRD;
               end
            end
            S_CPRD: begin
               state_ff <= S_CPWR;
            end
            S_CPWR: begin
               if (idx_is_end) begin
                  state_ff <= S_INS_LINK;
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_CPRD;
               end
            end
            S_INS_LINK: begin
               nodes_used_ff <= nodes_used_ff + PW'(1);
               result_ff     <= '{found: 1'b0, status: hwd_pkg::STATUS_DONE,
                                 word_count: hwd_pkg::COUNT_W'(nodes_used_ff + PW'(1))};
               state_ff      <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= result_ff;
                  state_ff     <= sweep_pend_ff ? S_SWEEP : S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      nodes_used_ff <= PW'(POOL_NODES))
      else $error("node count beyond pool size");
   a_sweep_no_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> !pop)
      else $error("queue popped during bucket sweep");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled response changed");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/hashed_word_dictionary.sv
// hashed_word_dictionary: top level, front classifier, entry queue and table back end
// depends on hwd_pkg, hwd_front, hwd_fifo, hwd_back
//
// Usage: requests carry one character each with an opcode (lookup, insert, clear)
// and a last flag. Lookup characters are lowercased; the word is hashed as it
// arrives. One response comes per last character or per clear: found, status
// and the stored word count. Opcode 3 is taken and dropped.
// A character is taken whenever the four-entry queue has room.
// At word end the back end reads the bucket head, after a bitwise bucket
// remainder when BUCKETS is not a power of two; a lookup then walks the chain,
// reading each node and, on a length match, comparing characters in turn, and an
// insert copies the word into the pool a character at a time. These memory reads set the rate.
// Clear and pool-full inserts answer at once, then sweep the bucket heads, one
// entry a cycle. After reset the same sweep runs first; requests are still
// taken into the queue meanwhile, but popped only once the back end is idle.
// The response sits in an output register; while the receiver stalls the back
// end waits with its next result and the queue fills, then req_ready drops.
`default_nettype none

module hashed_word_dictionary #(
   parameter int unsigned MAX_WORD   = 45,
   parameter int unsigned BUCKETS    = 4096,
   parameter int unsigned POOL_NODES = 1024
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  hwd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output hwd_pkg::rsp_type  rsp_data
);

   logic               push;
   hwd_pkg::entry_type push_entry;
   logic               pop;
   hwd_pkg::entry_type pop_entry;
   logic               queue_full;
   logic               queue_empty;

   hwd_front #(
      .MAX_WORD (MAX_WORD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   hwd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   hwd_back #(
      .MAX_WORD   (MAX_WORD),
      .BUCKETS    (BUCKETS),
      .POOL_NODES (POOL_NODES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

FILE: sim/hashed_word_dictionary_tb.sv
// hashed_word_dictionary_tb: self-checking bench for the chained-hash word dictionary
// depends on hwd_pkg and the hashed_word_dictionary rtl; predicts every response in-bench
`timescale 1ns / 1ps

module hashed_word_dictionary_tb;

   localparam int unsigned DICT_MAX_WORD = 45;
   localparam int unsigned DICT_BUCKETS  = 4096;
   localparam int unsigned DICT_POOL     = 1024;
   localparam logic [1:0]  OP_IGNORED    = 2'd3;
   localparam int unsigned VOCAB_SIZE    = 24;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   hwd_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   hwd_pkg::rsp_type rsp_data;

   hashed_word_dictionary dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // pending requests and the responses they are predicted to cause
   hwd_pkg::req_type pending_reqs[$];
   hwd_pkg::rsp_type expected_rsps[$];
   logic    req_took = 1'b0;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;
   int      mismatches = 0;
   int      n_reqs = 0, n_rsps = 0, n_found = 0, n_too_long = 0, n_pool_full = 0;

   // predicted dictionary state
   logic [7:0]  buf_chr [DICT_MAX_WORD];
   int          buf_len = 0;
   logic [31:0] buf_hash = '0;
   bit          buf_over = 0;
   logic [10:0] head_of [DICT_BUCKETS];
   logic [7:0]  node_chr [DICT_POOL][DICT_MAX_WORD];
   int          node_len [DICT_POOL];
   logic [10:0] node_nxt [DICT_POOL];
   int          words_held = 0;

   logic [7:0]  vocab_chr [VOCAB_SIZE][8];
   int          vocab_len [VOCAB_SIZE];

   task automatic empty_dict();
      for (int i = 0; i < DICT_BUCKETS; i++) head_of[i] = '0;
      words_held = 0;
   endtask

   task automatic dict_apply(input hwd_pkg::req_type r);
      logic [7:0]       c;
      logic [11:0]      bkt;
      int               nref;
      int               steps;
      int               n;
      bit               hit;
      bit               same;
      hwd_pkg::rsp_type e;
      e = '0;
      if (r.op == OP_IGNORED) return;
      if (r.op == hwd_pkg::OP_CLEAR) begin
         empty_dict();
         buf_len = 0; buf_hash = '0; buf_over = 0;
         expected_rsps.push_back(e);
         return;
      end
      c = r.char_code;
      if (r.op == hwd_pkg::OP_LOOKUP && c >= 8'h41 && c <= 8'h5a) c = c + 8'd32;
      buf_hash = (buf_hash << 2) ^ {24'd0, c};
      if (buf_len < DICT_MAX_WORD) begin
         buf_chr[buf_len] = c;
         buf_len++;
      end else begin
         buf_over = 1;
      end
      if (!r.last) return;
      bkt = buf_hash[11:0];
      if (buf_over) begin
         e.status = hwd_pkg::STATUS_TOO_LONG;
         n_too_long++;
      end else if (r.op == hwd_pkg::OP_LOOKUP) begin
         hit = 0;
         nref = head_of[bkt];
         steps = 0;
         while (nref != 0 && steps < DICT_POOL && !hit) begin
            n = nref - 1;
            if (node_len[n] == buf_len) begin
               same = 1;
               for (int i = 0; i < buf_len; i++)
                  if (node_chr[n][i] != buf_chr[i]) same = 0;
               hit = same;
            end
            nref = node_nxt[n];
            steps++;
         end
         e.found = hit;
         if (hit) n_found++;
      end else if (words_held >= DICT_POOL) begin
         empty_dict();
         e.status = hwd_pkg::STATUS_POOL_FULL;
         n_pool_full++;
      end else begin
         n = words_held;
         for (int i = 0; i < buf_len; i++) node_chr[n][i] = buf_chr[i];
         node_len[n] = buf_len;
         node_nxt[n] = head_of[bkt];
         head_of[bkt] = 11'(n + 1);
         words_held = n + 1;
      end
      e.word_count = 11'(words_held);
      buf_len = 0; buf_hash = '0; buf_over = 0;
      expected_rsps.push_back(e);
   endtask

   // driver: inputs move on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_took) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      hwd_pkg::rsp_type e;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            n_reqs++;
            dict_apply(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            n_rsps++;
            if (expected_rsps.size() == 0) begin
               $error("response with nothing expected: %p", rsp_data);
               mismatches++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_data.found !== e.found) begin
                  $error("found: expected %0d, got %0d", e.found, rsp_data.found);
                  mismatches++;
               end
               if (rsp_data.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.word_count !== e.word_count) begin
                  $error("word_count: expected %0d, got %0d",
                         e.word_count, rsp_data.word_count);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic send(input logic [1:0] op, input logic [7:0] c, input logic last);
      hwd_pkg::req_type r;
      r.op = op; r.char_code = c; r.last = last;
      pending_reqs.push_back(r);
   endtask

   // a vocabulary word, optionally with flipped letter case or mixed per-char ops
   task automatic send_vocab(input logic [1:0] op, input int idx, input bit mix,
                             input bit recase);
      logic [7:0] c;
      logic [1:0] o;
      for (int i = 0; i < vocab_len[idx]; i++) begin
         c = vocab_chr[idx][i];
         if (recase && $urandom_range(1) && ((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7a))
            c = c ^ 8'h20;
         o = (mix && i != vocab_len[idx] - 1) ? 2'($urandom_range(1)) : op;
         send(o, c, i == vocab_len[idx] - 1);
      end
   endtask

   task automatic send_random_word(input logic [1:0] op, input int len);
      for (int i = 0; i < len; i++) send(op, 8'($urandom_range(255)), i == len - 1);
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic random_phase(input int n_items);
      int target;
      int pick;
      target = pending_reqs.size() + n_items;
      while (pending_reqs.size() < target) begin
         pick = $urandom_range(99);
         if (pick < 40)
            send_vocab(hwd_pkg::OP_INSERT, $urandom_range(VOCAB_SIZE - 1), 0, 0);
         else if (pick < 80)
            send_vocab(hwd_pkg::OP_LOOKUP, $urandom_range(VOCAB_SIZE - 1), 0, 1);
         else if (pick < 85)
            send_vocab($urandom_range(1) ? hwd_pkg::OP_INSERT : hwd_pkg::OP_LOOKUP,
                       $urandom_range(VOCAB_SIZE - 1), 1, 1);
         else if (pick < 91)
            send_random_word($urandom_range(1) ? hwd_pkg::OP_INSERT : hwd_pkg::OP_LOOKUP,
                             $urandom_range(1, 6));
         else if (pick < 94)
            send_random_word($urandom_range(1) ? hwd_pkg::OP_INSERT : hwd_pkg::OP_LOOKUP,
                             $urandom_range(44, 48));
         else if (pick < 96)
            send(OP_IGNORED, 8'($urandom_range(255)), 1'($urandom_range(1)));
         else if (pick < 98) begin
            // partial word cut short by a clear
            send(hwd_pkg::OP_INSERT, 8'($urandom_range(255)), 1'b0);
            send(hwd_pkg::OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else
            send(hwd_pkg::OP_CLEAR, 8'($urandom_range(255)), 1'b1);
      end
   endtask

   initial begin
      for (int i = 0; i < DICT_BUCKETS; i++) head_of[i] = '0;
      for (int v = 0; v < VOCAB_SIZE; v++) begin
         vocab_len[v] = $urandom_range(1, 8);
         for (int i = 0; i < 8; i++)
            vocab_chr[v][i] = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                              : 8'($urandom_range(8'h41, 8'h7a));
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part
      send(hwd_pkg::OP_LOOKUP, 8'h63, 1'b1);
      send(hwd_pkg::OP_INSERT, 8'h43, 1'b0); send(hwd_pkg::OP_INSERT, 8'h61, 1'b0);
      send(hwd_pkg::OP_INSERT, 8'h74, 1'b1);
      send(hwd_pkg::OP_LOOKUP, 8'h43, 1'b0); send(hwd_pkg::OP_LOOKUP, 8'h41, 1'b0);
      send(hwd_pkg::OP_LOOKUP, 8'h54, 1'b1);              // lowercased: misses "Cat"
      send(hwd_pkg::OP_INSERT, 8'h00, 1'b0); send(hwd_pkg::OP_INSERT, 8'hff, 1'b1);
      send(hwd_pkg::OP_INSERT, 8'h00, 1'b0); send(hwd_pkg::OP_INSERT, 8'hff, 1'b1);
      send(hwd_pkg::OP_LOOKUP, 8'h00, 1'b0); send(hwd_pkg::OP_LOOKUP, 8'hff, 1'b1);
      send(hwd_pkg::OP_INSERT, 8'h5a, 1'b0); send(hwd_pkg::OP_LOOKUP, 8'h41, 1'b1);
      send(OP_IGNORED, 8'h55, 1'b1);
      send(hwd_pkg::OP_INSERT, 8'h41, 1'b0);
      send(hwd_pkg::OP_CLEAR, 8'h00, 1'b0);               // clear drops partial word
      send_random_word(hwd_pkg::OP_INSERT, 45);
      send_random_word(hwd_pkg::OP_LOOKUP, 46);           // one past the maximum
      drain();

      // pool exhaustion, then one more insert
      for (int i = 0; i < DICT_POOL + 1; i++)
         send(hwd_pkg::OP_INSERT, 8'($urandom_range(255)), 1'b1);
      send(hwd_pkg::OP_LOOKUP, 8'h61, 1'b1);
      drain();

      random_phase(80);
      drain();
      send_idle_pct = 47;
      random_phase(80);
      drain();
      send_idle_pct = 0; rsp_stall_pct = 47;
      random_phase(80);
      drain();
      send_idle_pct = 30; rsp_stall_pct = 30;
      random_phase(80);
      drain();
      repeat (50) @(posedge clock);

      $display("covered %0d requests, %0d responses: %0d hits, %0d over-length, %0d pool-full",
               n_reqs, n_rsps, n_found, n_too_long, n_pool_full);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
